// ===== design/prp_pkg.sv =====
// shared types and constants for the point rotate and project block
`timescale 1ns / 1ps

package prp_pkg;

	localparam int COORD_BITS     = 12;
	localparam int TRIG_FRAC_BITS = 14;
	localparam int TRIG_FRAC_MAX  = 16;
	localparam int TRIG_BITS      = 16;
	localparam int SIZE_BITS      = 13;
	localparam int PITCH_BITS     = 15;
	localparam int DIST_BITS      = 12;
	localparam int SCREEN_BITS    = 12;
	localparam int OFFSET_BITS    = 26;
	localparam int PIXEL_SHIFT    = 2;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [SIZE_BITS-1:0]        SCREEN_MAX     = 13'd4096;
	localparam logic signed [TRIG_BITS-1:0] COS_RESET      = 16'sd16384;
	localparam logic signed [TRIG_BITS-1:0] SIN_RESET      = 16'sd0;
	localparam logic [SIZE_BITS-1:0]        WIDTH_RESET    = 13'd640;
	localparam logic [SIZE_BITS-1:0]        HEIGHT_RESET   = 13'd480;
	localparam logic [PITCH_BITS-1:0]       PITCH_RESET    = 15'd2560;
	localparam logic [DIST_BITS-1:0]        DIST_RESET     = 12'd300;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_COS    = 3'd0,
		CFG_SIN    = 3'd1,
		CFG_WIDTH  = 3'd2,
		CFG_HEIGHT = 3'd3,
		CFG_PITCH  = 3'd4,
		CFG_DIST   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic                    visible;
		logic [SCREEN_BITS-1:0]  screen_x;
		logic [SCREEN_BITS-1:0]  screen_y;
		logic [OFFSET_BITS-1:0]  byte_offset;
	} pixel_t;

endpackage

// ===== design/point_rotate_project_core.sv =====
`timescale 1ns / 1ps
// point_rotate_project_core: y-axis rotation, perspective projection and pixel addressing
//
// point channel: one 3D point per word (valid/ready). pixel channel: one result word per
// point, in order, with visible flag, screen column/row and framebuffer byte offset
// (row * pitch + column * 4). invisible points report zeros.
// cfg channel: cfg_index selects cos, sin, width, height, pitch or view distance;
// cfg_ready is always high. write registers only while no point is in flight.
// throughput: one point per cycle while the receiver keeps pixel_ready high. 22 register
// stages lie between an accepted point and its pixel word:
// multiply, rotate, depth, scale, numerator, magnitude, dividend, then one overflow
// stage and twelve restoring divide stages (one quotient bit each, x and y lanes side
// by side), bounds check with row multiply, output.
// each stage holds while the stage after it is full and stalled, so a stalled receiver
// lets bubbles close up before point_ready drops; nothing is lost or repeated.
// reset clears all valid bits and loads the register defaults (cos 1.0, sin 0,
// 640x480, pitch 2560, distance 300).

module point_rotate_project_core #(
	parameter int TRIG_FRAC_BITS = prp_pkg::TRIG_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                point_valid,
	output logic                                point_ready,
	input  prp_pkg::point_t                     point,
	output logic                                pixel_valid,
	input  logic                                pixel_ready,
	output prp_pkg::pixel_t                     pixel,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [prp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [prp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import prp_pkg::*;

	localparam int F_EFF  = (TRIG_FRAC_BITS > TRIG_FRAC_MAX) ? TRIG_FRAC_MAX : TRIG_FRAC_BITS;
	localparam int PW     = COORD_BITS + TRIG_BITS;
	localparam int ROT_W  = PW + 1;
	localparam int DSH_W  = DIST_BITS + F_EFF + 1;
	localparam int DEN_W  = ((DSH_W > ROT_W) ? DSH_W : ROT_W) + 1;
	localparam int XRD_W  = ROT_W + DIST_BITS + 1;
	localparam int YD_W   = COORD_BITS + DIST_BITS + 1;
	localparam int SZ_W   = SIZE_BITS + 1;
	localparam int HDEN_W = DEN_W + SZ_W;
	localparam int T2_W   = XRD_W + 1;
	localparam int T3_W   = YD_W + F_EFF + 1;
	localparam int T23_W  = (T2_W > T3_W) ? T2_W : T3_W;
	localparam int NUM_W  = ((HDEN_W > T23_W) ? HDEN_W : T23_W) + 1;
	localparam int RW     = NUM_W + 1;
	localparam int QW     = SCREEN_BITS;
	localparam int PROD_W = SCREEN_BITS + PITCH_BITS;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [QW-1:0] quo;
		logic          neg;
		logic          ovf;
	} div_lane_t;

	// configuration registers
	logic signed [TRIG_BITS-1:0] cos_q, sin_q;
	logic [SIZE_BITS-1:0]        width_q, height_q;
	logic [PITCH_BITS-1:0]       pitch_q;
	logic [DIST_BITS-1:0]        dist_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= COS_RESET;
			sin_q    <= SIN_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			pitch_q  <= PITCH_RESET;
			dist_q   <= DIST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_COS:    cos_q <= $signed(cfg_data[TRIG_BITS-1:0]);
				CFG_SIN:    sin_q <= $signed(cfg_data[TRIG_BITS-1:0]);
				CFG_WIDTH: begin
					width_q <= (cfg_data[SIZE_BITS-1:0] > SCREEN_MAX) ? SCREEN_MAX
						: cfg_data[SIZE_BITS-1:0];
				end
				CFG_HEIGHT: begin
					height_q <= (cfg_data[SIZE_BITS-1:0] > SCREEN_MAX) ? SCREEN_MAX
						: cfg_data[SIZE_BITS-1:0];
				end
				CFG_PITCH:  pitch_q <= cfg_data[PITCH_BITS-1:0];
				CFG_DIST:   dist_q <= cfg_data[DIST_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic signed [DIST_BITS:0] dist_s;
	logic signed [SZ_W-1:0]    width_s, height_s;

	assign dist_s   = $signed({1'b0, dist_q});
	assign width_s  = $signed({1'b0, width_q});
	assign height_s = $signed({1'b0, height_q});

	// valid and ready chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8, rdy_s9;
	logic [QW:0] dv_sd;
	logic [QW:0] dr_sd;

	assign rdy_s9     = !v_s9 || pixel_ready;
	assign rdy_s8     = !v_s8 || rdy_s9;
	assign dr_sd[QW]  = !dv_sd[QW] || rdy_s8;
	assign rdy_s7     = !v_s7 || dr_sd[0];
	assign rdy_s6     = !v_s6 || rdy_s7;
	assign rdy_s5     = !v_s5 || rdy_s6;
	assign rdy_s4     = !v_s4 || rdy_s5;
	assign rdy_s3     = !v_s3 || rdy_s4;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign point_ready = rdy_s1;

	for (genvar k = 0; k < QW; k++) begin : g_rdy
		assign dr_sd[k] = !dv_sd[k] || dr_sd[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			dv_sd <= '0;
		end else begin
			if (rdy_s1) v_s1 <= point_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
			if (dr_sd[0]) dv_sd[0] <= v_s7;
			for (int k = 1; k <= QW; k++) begin
				if (dr_sd[k]) dv_sd[k] <= dv_sd[k-1];
			end
			if (rdy_s8) v_s8 <= dv_sd[QW];
			if (rdy_s9) v_s9 <= v_s8;
		end
	end

	// s1: rotation products
	logic signed [PW-1:0]         xc_s1, zs_s1, zc_s1, xs_s1;
	logic signed [COORD_BITS-1:0] y_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			xc_s1 <= PW'(point.point_x) * PW'(cos_q);
			zs_s1 <= PW'(point.point_z) * PW'(sin_q);
			zc_s1 <= PW'(point.point_z) * PW'(cos_q);
			xs_s1 <= PW'(point.point_x) * PW'(sin_q);
			y_s1  <= point.point_y;
		end
	end

	// s2: rotated x and z in q.frac
	logic signed [ROT_W-1:0]      xr_s2, zr_s2;
	logic signed [COORD_BITS-1:0] y_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			xr_s2 <= ROT_W'(xc_s1) + ROT_W'(zs_s1);
			zr_s2 <= ROT_W'(zc_s1) - ROT_W'(xs_s1);
			y_s2  <= y_s1;
		end
	end

	// s3: depth and distance products
	logic signed [DEN_W-1:0] den_s3;
	logic signed [XRD_W-1:0] xrd_s3;
	logic signed [YD_W-1:0]  yd_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			den_s3 <= (DEN_W'(dist_s) <<< F_EFF) + DEN_W'(zr_s2);
			xrd_s3 <= XRD_W'(xr_s2) * XRD_W'(dist_s);
			yd_s3  <= YD_W'(y_s2) * YD_W'(dist_s);
		end
	end

	// s4: screen size times depth
	logic signed [HDEN_W-1:0] wden_s4, hden_s4;
	logic signed [DEN_W-1:0]  den_s4;
	logic signed [XRD_W-1:0]  xrd_s4;
	logic signed [YD_W-1:0]   yd_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			wden_s4 <= HDEN_W'(den_s3) * HDEN_W'(width_s);
			hden_s4 <= HDEN_W'(den_s3) * HDEN_W'(height_s);
			den_s4  <= den_s3;
			xrd_s4  <= xrd_s3;
			yd_s4   <= yd_s3;
		end
	end

	// s5: numerators of (W*den + 2*xr*D) / (2*den) and the y counterpart
	logic signed [NUM_W-1:0] nx_s5, ny_s5;
	logic signed [DEN_W-1:0] den_s5;
	logic                    dpos_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			nx_s5   <= NUM_W'(wden_s4) + (NUM_W'(xrd_s4) <<< 1);
			ny_s5   <= NUM_W'(hden_s4) + (NUM_W'(yd_s4) <<< (F_EFF + 1));
			den_s5  <= den_s4;
			dpos_s5 <= (den_s4 > 0);
		end
	end

	// s6: sign and magnitude
	logic [NUM_W-1:0]        magx_s6, magy_s6;
	logic                    negx_s6, negy_s6, dpos_s6;
	logic signed [DEN_W-1:0] den_s6;

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			negx_s6 <= nx_s5[NUM_W-1];
			negy_s6 <= ny_s5[NUM_W-1];
			magx_s6 <= nx_s5[NUM_W-1] ? NUM_W'(-nx_s5) : NUM_W'(nx_s5);
			magy_s6 <= ny_s5[NUM_W-1] ? NUM_W'(-ny_s5) : NUM_W'(ny_s5);
			den_s6  <= den_s5;
			dpos_s6 <= dpos_s5;
		end
	end

	// s7: rounding folds into floor((mag + den) / (2*den))
	logic [RW-1:0]    nnx_s7, nny_s7;
	logic [DEN_W-1:0] vd_s7;
	logic             negx_s7, negy_s7, dpos_s7;

	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			nnx_s7  <= RW'(magx_s6) + RW'($unsigned(den_s6));
			nny_s7  <= RW'(magy_s6) + RW'($unsigned(den_s6));
			vd_s7   <= {den_s6[DEN_W-2:0], 1'b0};
			negx_s7 <= negx_s6;
			negy_s7 <= negy_s6;
			dpos_s7 <= dpos_s6;
		end
	end

	// divider: stage 0 flags quotients that cannot fit, stages 1..QW take one bit each
	div_lane_t        dx_sd   [QW+1];
	div_lane_t        dy_sd   [QW+1];
	logic [DEN_W-1:0] dvs_sd  [QW+1];
	logic             dpos_sd [QW+1];

	logic [RW-1:0] lim_d0;
	assign lim_d0 = RW'(vd_s7) << QW;

	always_ff @(posedge clk) begin
		if (dr_sd[0]) begin
			dx_sd[0]   <= '{rem: nnx_s7, quo: '0, neg: negx_s7, ovf: (nnx_s7 >= lim_d0)};
			dy_sd[0]   <= '{rem: nny_s7, quo: '0, neg: negy_s7, ovf: (nny_s7 >= lim_d0)};
			dvs_sd[0]  <= vd_s7;
			dpos_sd[0] <= dpos_s7;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_div
		localparam int BIT = QW - k;
		logic [RW-1:0] sh;
		div_lane_t     nxt_x, nxt_y;

		assign sh = RW'(dvs_sd[k-1]) << BIT;

		always_comb begin
			nxt_x = dx_sd[k-1];
			nxt_y = dy_sd[k-1];
			if (dx_sd[k-1].rem >= sh) begin
				nxt_x.rem      = dx_sd[k-1].rem - sh;
				nxt_x.quo[BIT] = 1'b1;
			end
			if (dy_sd[k-1].rem >= sh) begin
				nxt_y.rem      = dy_sd[k-1].rem - sh;
				nxt_y.quo[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (dr_sd[k]) begin
				dx_sd[k]   <= nxt_x;
				dy_sd[k]   <= nxt_y;
				dvs_sd[k]  <= dvs_sd[k-1];
				dpos_sd[k] <= dpos_sd[k-1];
			end
		end
	end

	// s8: bounds check and row offset
	logic                   visx, visy;
	logic                   vis_s8;
	logic [QW-1:0]          sx_s8;
	logic [PROD_W-1:0]      prod_s8;

	// a negative value that rounds to zero still lands on column or row zero
	assign visx = !dx_sd[QW].ovf && (!dx_sd[QW].neg || dx_sd[QW].quo == '0)
		&& (SIZE_BITS'(dx_sd[QW].quo) < width_q);
	assign visy = !dy_sd[QW].ovf && (!dy_sd[QW].neg || dy_sd[QW].quo == '0)
		&& (SIZE_BITS'(dy_sd[QW].quo) < height_q);

	logic [QW-1:0] sy_s8;

	always_ff @(posedge clk) begin
		if (rdy_s8) begin
			vis_s8  <= dpos_sd[QW] && visx && visy;
			sx_s8   <= dx_sd[QW].quo;
			sy_s8   <= dy_sd[QW].quo;
			prod_s8 <= PROD_W'(dy_sd[QW].quo) * PROD_W'(pitch_q);
		end
	end

	// s9: output word
	pixel_t            pixel_s9;
	logic [PROD_W-1:0] addr_sum;

	assign addr_sum = prod_s8 + (PROD_W'(sx_s8) << PIXEL_SHIFT);

	always_ff @(posedge clk) begin
		if (rdy_s9) begin
			pixel_s9.visible     <= vis_s8;
			pixel_s9.screen_x    <= vis_s8 ? sx_s8 : '0;
			pixel_s9.screen_y    <= vis_s8 ? sy_s8 : '0;
			pixel_s9.byte_offset <= vis_s8 ? addr_sum[OFFSET_BITS-1:0] : '0;
		end
	end

	assign pixel_valid = v_s9;
	assign pixel       = pixel_s9;

endmodule

// ===== design/prp_checker.sv =====
// port-level checks for point_rotate_project_core and the bind that attaches them
`timescale 1ns / 1ps

module prp_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            point_ready,
	input  logic            pixel_valid,
	input  logic            pixel_ready,
	input  prp_pkg::pixel_t pixel
);
	import prp_pkg::*;

	// a held output word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel))
		else $error("pixel word changed while stalled");

	// an empty output stage means the whole pipe can move
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_valid |-> point_ready)
		else $error("point_ready low with empty output stage");

	// off-screen words carry no coordinates
	a_invisible_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel.visible |-> pixel.screen_x == '0 && pixel.screen_y == '0
			&& pixel.byte_offset == '0)
		else $error("invisible word with nonzero fields");

	// no word right out of reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !pixel_valid)
		else $error("pixel_valid right after reset");

endmodule

bind point_rotate_project_core prp_checker u_prp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.point_ready (point_ready),
	.pixel_valid (pixel_valid),
	.pixel_ready (pixel_ready),
	.pixel       (pixel)
);

// ===== test/tb_point_rotate_project_core.sv =====
// testbench for point_rotate_project_core: random and corner points checked against a predictor
`timescale 1ns / 1ps

module tb_point_rotate_project_core;
	import prp_pkg::*;

	localparam int PIPE_LATENCY   = 22;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TRIG_FRAC      = (TRIG_FRAC_BITS > TRIG_FRAC_MAX) ? TRIG_FRAC_MAX
	                                                                 : TRIG_FRAC_BITS;
	localparam longint TRIG_ONE   = longint'(1) << TRIG_FRAC;
	// no register sits at this index, writes to it must change nothing
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 3'd6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic point_valid = 1'b0;
	logic point_ready;
	point_t point = '0;
	logic pixel_valid;
	logic pixel_ready = 1'b0;
	pixel_t pixel;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	point_rotate_project_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point(point),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// copy of the view registers as the block should hold them
	logic signed [TRIG_BITS-1:0] view_cos = COS_RESET;
	logic signed [TRIG_BITS-1:0] view_sin = SIN_RESET;
	logic [SIZE_BITS-1:0] view_width = WIDTH_RESET;
	logic [SIZE_BITS-1:0] view_height = HEIGHT_RESET;
	logic [PITCH_BITS-1:0] view_pitch = PITCH_RESET;
	logic [DIST_BITS-1:0] view_dist = DIST_RESET;

	point_t pending_points[$];
	pixel_t expected_pixels[$];

	int queued_points = 0;
	int accepted_points = 0;
	int pixels_checked = 0;
	int pixels_on_screen = 0;
	int reg_writes = 0;
	int view_settings = 1;
	int errors = 0;
	int stall_cycles = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int src_gap = 0;
	int snk_gap = 0;
	logic point_taken = 1'b0;
	logic cfg_taken = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	// round n/d half away from zero, d > 0
	function automatic longint div_round(longint n, longint d);
		longint mag, q;
		mag = (n < 0) ? -n : n;
		q = (2 * mag + d) / (2 * d);
		return (n < 0) ? -q : q;
	endfunction

	function automatic pixel_t project_point(point_t p);
		longint px, py, pz, c, s, w, h, d, pitch, xr, zr, den, sx, sy, offs;
		pixel_t r;
		r = '0;
		px = longint'(p.point_x);
		py = longint'(p.point_y);
		pz = longint'(p.point_z);
		c = longint'(view_cos);
		s = longint'(view_sin);
		w = longint'((view_width > SCREEN_MAX) ? SCREEN_MAX : view_width);
		h = longint'((view_height > SCREEN_MAX) ? SCREEN_MAX : view_height);
		d = longint'(view_dist);
		pitch = longint'(view_pitch);
		xr = px * c + pz * s;
		zr = pz * c - px * s;
		den = d * TRIG_ONE + zr;
		if (den <= 0)
			return r;
		// center plus projected offset, as one exact fraction
		sx = div_round(w * den + 2 * xr * d, 2 * den);
		sy = div_round(h * den + 2 * py * TRIG_ONE * d, 2 * den);
		if (sx < 0 || sx >= w || sy < 0 || sy >= h)
			return r;
		offs = sy * pitch + sx * (longint'(1) << PIXEL_SHIFT);
		r.visible = 1'b1;
		r.screen_x = sx[SCREEN_BITS-1:0];
		r.screen_y = sy[SCREEN_BITS-1:0];
		r.byte_offset = offs[OFFSET_BITS-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [OFFSET_BITS-1:0] want,
			logic [OFFSET_BITS-1:0] got);
		if (got !== want) begin
			$display("%0t: pixel %0d %s expected %0d got %0d",
				$time, pixels_checked, name, want, got);
			errors++;
		end
	endtask

	always @(negedge clk) begin : point_driver
		if (!point_valid || point_taken) begin
			if (src_gap != 0) begin
				point_valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (pending_points.size() == 0) begin
				point_valid <= 1'b0;
			end else if ($urandom_range(99, 0) < src_idle_pct) begin
				point_valid <= 1'b0;
				src_gap <= $urandom_range(17, 0);
			end else begin
				point <= pending_points.pop_front();
				point_valid <= 1'b1;
			end
		end
	end

	always @(negedge clk) begin : pixel_sink
		if (snk_gap != 0) begin
			pixel_ready <= 1'b0;
			snk_gap <= snk_gap - 1;
		end else if ($urandom_range(99, 0) < snk_idle_pct) begin
			pixel_ready <= 1'b0;
			snk_gap <= $urandom_range(17, 0);
		end else begin
			pixel_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		pixel_t want;
		point_taken <= point_valid && point_ready;
		cfg_taken <= cfg_valid && cfg_ready;
		if ((point_valid && point_ready) || (pixel_valid && pixel_ready)
				|| (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (cfg_valid && cfg_ready) begin
			reg_writes++;
			case (cfg_index)
				CFG_COS: view_cos = cfg_data;
				CFG_SIN: view_sin = cfg_data;
				CFG_WIDTH: view_width = cfg_data[SIZE_BITS-1:0];
				CFG_HEIGHT: view_height = cfg_data[SIZE_BITS-1:0];
				CFG_PITCH: view_pitch = cfg_data[PITCH_BITS-1:0];
				CFG_DIST: view_dist = cfg_data[DIST_BITS-1:0];
				default: ;
			endcase
		end
		if (point_valid && point_ready) begin
			expected_pixels.push_back(project_point(point));
			accepted_points++;
		end
		if (pixel_valid && pixel_ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: pixel word with nothing expected, got %h", $time, pixel);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("visible", OFFSET_BITS'(want.visible),
					OFFSET_BITS'(pixel.visible));
				check_field("screen_x", OFFSET_BITS'(want.screen_x),
					OFFSET_BITS'(pixel.screen_x));
				check_field("screen_y", OFFSET_BITS'(want.screen_y),
					OFFSET_BITS'(pixel.screen_y));
				check_field("byte_offset", want.byte_offset, pixel.byte_offset);
				if (want.visible)
					pixels_on_screen++;
				pixels_checked++;
			end
		end
	end

	initial begin : watchdog
		while (stall_cycles < WATCHDOG_LIMIT)
			@(negedge clk);
		$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the write
	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(negedge clk);
		while (!cfg_taken);
	endtask

	task automatic set_view(int c, int s, int w, int h, int pitch, int d);
		write_reg(CFG_COS, CFG_DATA_BITS'(c));
		write_reg(CFG_SIN, CFG_DATA_BITS'(s));
		write_reg(CFG_WIDTH, CFG_DATA_BITS'(w));
		write_reg(CFG_HEIGHT, CFG_DATA_BITS'(h));
		write_reg(CFG_PITCH, CFG_DATA_BITS'(pitch));
		write_reg(CFG_DIST, CFG_DATA_BITS'(d));
		cfg_valid <= 1'b0;
		view_settings++;
	endtask

	task automatic random_view();
		real ang;
		int c, s, w, h, pitch;
		ang = $urandom_range(359, 0) * 3.14159265358979 / 180.0;
		c = $rtoi($cos(ang) * 16384.0);
		s = $rtoi($sin(ang) * 16384.0);
		// now and then trig words outside the unit range
		if ($urandom_range(4, 0) == 0) begin
			c = $urandom;
			s = $urandom;
		end
		w = ($urandom_range(6, 0) == 0) ? $urandom_range(8191, 4097) : $urandom_range(4096, 1);
		h = ($urandom_range(6, 0) == 0) ? $urandom_range(8191, 4097) : $urandom_range(4096, 1);
		if ($urandom_range(3, 0) == 0)
			pitch = $urandom_range(32767, 0);
		else
			pitch = ((w > 4096) ? 4096 : w) * 4 + $urandom_range(64, 0);
		if (pitch > 32767)
			pitch = 32767;
		set_view(c, s, w, h, pitch, $urandom_range(4095, 1));
	endtask

	task automatic add_point(int x, int y, int z);
		point_t p;
		p.point_x = COORD_BITS'(x);
		p.point_y = COORD_BITS'(y);
		p.point_z = COORD_BITS'(z);
		pending_points.push_back(p);
		queued_points++;
	endtask

	// mostly points sized to land on screen for the current view, the rest anywhere
	task automatic add_random_points(int n);
		int span, lim;
		span = int'(view_dist) / 2;
		lim = int'((view_width < view_height) ? view_width : view_height) / 4;
		if (lim < span)
			span = lim;
		if (span < 1)
			span = 1;
		if (span > 2047)
			span = 2047;
		repeat (n) begin
			if ($urandom_range(9, 0) < 4)
				add_point($urandom, $urandom, $urandom);
			else
				add_point($urandom_range(2 * span, 0) - span,
					$urandom_range(2 * span, 0) - span,
					$urandom_range(2 * span, 0) - span);
		end
	endtask

	task automatic drain();
		while (accepted_points != queued_points || expected_pixels.size() != 0)
			@(negedge clk);
	endtask

	task automatic pick_idling();
		int pick[4] = '{0, 8, 25, 45};
		src_idle_pct = pick[$urandom_range(3, 0)];
		snk_idle_pct = pick[$urandom_range(3, 0)];
	endtask

	initial begin : stimulus
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset view: center, edges, depth limits, half pixel rounding
		src_idle_pct = 10;
		snk_idle_pct = 10;
		add_point(0, 0, 0);
		add_point(2047, 2047, 2047);
		add_point(-2048, -2048, -2048);
		add_point(2047, 0, 0);
		add_point(-2048, 0, 0);
		add_point(0, 2047, 0);
		add_point(0, -2048, 0);
		add_point(0, 0, 2047);
		add_point(0, 0, -2048);
		add_point(0, 0, -300);
		add_point(0, 0, -299);
		add_point(1, -1, -299);
		add_point(-320, -240, 0);
		add_point(320, 240, 0);
		add_point(1, 0, 300);
		add_point(-1, 0, 300);
		add_random_points(70);
		drain();

		// quarter turn, odd screen size
		set_view(0, 16384, 641, 479, 4096, 512);
		src_idle_pct = 30;
		snk_idle_pct = 0;
		add_random_points(70);
		drain();

		// extreme trig words, oversized screen, offset wraps
		set_view('h8000, 'h7fff, 8191, 4096, 32767, 4095);
		src_idle_pct = 0;
		snk_idle_pct = 30;
		add_random_points(70);
		drain();

		// zero view distance, tiny screen
		set_view(16384, 0, 2, 2, 4, 0);
		write_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));
		cfg_valid <= 1'b0;
		src_idle_pct = 20;
		snk_idle_pct = 20;
		add_point(0, 0, 1);
		add_point(0, 0, 0);
		add_point(3, -2, -1);
		add_point(2047, -2048, 5);
		add_random_points(70);
		drain();

		// width word with only upper bits set masks to zero, so nothing is on screen
		set_view(-16384, -16384, 'he000, 0, 4, 4095);
		src_idle_pct = 5;
		snk_idle_pct = 40;
		add_random_points(70);
		drain();

		// half turn, largest screen, pitch of four bytes, distance one
		set_view(-16384, 0, 4096, 4096, 4, 1);
		src_idle_pct = 40;
		snk_idle_pct = 5;
		add_random_points(70);
		drain();

		repeat (6) begin
			random_view();
			pick_idling();
			add_random_points(70);
			drain();
		end

		// closing stretch at full rate
		set_view(int'(COS_RESET), int'(SIN_RESET), int'(WIDTH_RESET), int'(HEIGHT_RESET),
			16384, int'(DIST_RESET));
		src_idle_pct = 0;
		snk_idle_pct = 0;
		add_random_points(110);
		drain();

		repeat (PIPE_LATENCY + 8) @(negedge clk);
		$display("checked %0d points (%0d on screen) over %0d view settings, %0d register writes",
			pixels_checked, pixels_on_screen, view_settings, reg_writes);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
